// ===== rtl/buddy_memory_allocator_unit_macros.svh =====
// assertion macros shared by the checker
`ifndef BUDDY_MEMORY_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_MEMORY_ALLOCATOR_UNIT_MACROS_SVH

// condition holds in the same cycle
`define BMA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the following cycle
`define BMA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// checked also while reset is high
`define BMA_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bma_pkg.sv =====
package bma_pkg;

   localparam int DEF_TOTAL_BYTES = 1024;
   localparam int DEF_MIN_BLOCK   = 1;

   localparam int CMD_W   = 2;
   localparam int OWNER_W = 16;
   localparam int PROC_W  = 15;
   localparam int SIZE_W  = 11;
   localparam int ADDR_W  = 10;
   localparam int NPROC_W = 16;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BIND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

   localparam logic [1:0] NS_UNUSED = 2'd0;
   localparam logic [1:0] NS_FREE   = 2'd1;
   localparam logic [1:0] NS_ALLOC  = 2'd2;
   localparam logic [1:0] NS_SPLIT  = 2'd3;

   localparam logic [NPROC_W-1:0] PROC_NONE = 16'hFFFF;

   typedef struct packed {
      logic [1:0]         status;
      logic [NPROC_W-1:0] proc;
      logic [OWNER_W-1:0] owner;
      logic [SIZE_W-1:0]  bytes;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NEED,
      ST_READ,
      ST_EVAL,
      ST_SPLIT_L,
      ST_SPLIT_R,
      ST_NEXT,
      ST_MRG_READ,
      ST_MRG_EVAL,
      ST_MRG_BUD,
      ST_MRG_PAR,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/bma_ram.sv =====
module bma_ram
   import bma_pkg::*;
#(
   parameter int WIDTH = NODE_W,
   parameter int DEPTH = 2 * DEF_TOTAL_BYTES - 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/bma_ctrl.sv =====
module bma_ctrl
   import bma_pkg::*;
#(
   parameter int TOTAL_BYTES = DEF_TOTAL_BYTES,
   parameter int MIN_BLOCK   = DEF_MIN_BLOCK,
   localparam int NODE_COUNT = 2 * (TOTAL_BYTES / MIN_BLOCK) - 1,
   localparam int NW         = $clog2(NODE_COUNT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [OWNER_W-1:0] req_owner_id,
   input  logic [PROC_W-1:0]  req_proc_id,
   input  logic [SIZE_W-1:0]  req_req_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [ADDR_W-1:0]  rsp_start_addr,
   output logic [ADDR_W-1:0]  rsp_end_addr,
   output logic [SIZE_W-1:0]  rsp_used_bytes,
   output logic [OWNER_W-1:0] rsp_block_owner,
   output logic               mem_wr_en,
   output logic [NW-1:0]      mem_wr_addr,
   output node_type           mem_wr_data,
   output logic [NW-1:0]      mem_rd_addr,
   input  node_type           mem_rd_data
);

   localparam int SW0 = $clog2(TOTAL_BYTES) + 2;
   localparam int SW  = (SW0 > SIZE_W + 1) ? SW0 : SIZE_W + 1;

   state_type state_ff, state_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] node_ff, node_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] base_ff, base_in;
   logic [SW-1:0] need_ff, need_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [OWNER_W-1:0] owner_ff, owner_in;
   logic [PROC_W-1:0]  proc_ff, proc_in;
   logic [SIZE_W-1:0]  req_ff, req_in;
   logic               res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]  res_start_ff, res_start_in;
   logic [ADDR_W-1:0]  res_end_ff, res_end_in;
   logic [SIZE_W-1:0]  res_bytes_ff, res_bytes_in;
   logic [OWNER_W-1:0] res_owner_ff, res_owner_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [ADDR_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [ADDR_W-1:0]  rsp_end_ff, rsp_end_in;
   logic [SIZE_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic [OWNER_W-1:0] rsp_owner_ff, rsp_owner_in;

   logic [NW-1:0] left_node, right_node, parent_node, buddy_node;
   logic          key_hit;

   assign left_node   = NW'({node_ff, 1'b1});
   assign right_node  = left_node + NW'(1);
   assign parent_node = NW'((node_ff - NW'(1)) >> 1);
   assign buddy_node  = node_ff[0] ? node_ff + NW'(1) : node_ff - NW'(1);
   assign key_hit     = (cmd_ff == CMD_BIND) ? (mem_rd_data.owner == owner_ff)
                                             : (mem_rd_data.proc == NPROC_W'(proc_ff));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      size_ff      <= size_in;
      base_ff      <= base_in;
      need_ff      <= need_in;
      cmd_ff       <= cmd_in;
      owner_ff     <= owner_in;
      proc_ff      <= proc_in;
      req_ff       <= req_in;
      res_ok_ff    <= res_ok_in;
      res_start_ff <= res_start_in;
      res_end_ff   <= res_end_in;
      res_bytes_ff <= res_bytes_in;
      res_owner_ff <= res_owner_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_owner_ff <= rsp_owner_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      node_in      = node_ff;
      size_in      = size_ff;
      base_in      = base_ff;
      need_in      = need_ff;
      cmd_in       = cmd_ff;
      owner_in     = owner_ff;
      proc_in      = proc_ff;
      req_in       = req_ff;
      res_ok_in    = res_ok_ff;
      res_start_in = res_start_ff;
      res_end_in   = res_end_ff;
      res_bytes_in = res_bytes_ff;
      res_owner_in = res_owner_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_owner_in = rsp_owner_ff;
      req_stall    = 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = node_ff;
      mem_wr_data  = '{status: NS_UNUSED, proc: PROC_NONE, owner: '0, bytes: '0};
      mem_rd_addr  = node_ff;

      case (state_ff)
         // clearing pass over the node memory
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            if (clr_ff == '0) begin
               mem_wr_data.status = NS_FREE;
            end
            if (clr_ff == NW'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + NW'(1);
            end
         end

         // command transfer
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_in       = req_cmd;
               owner_in     = req_owner_id;
               proc_in      = req_proc_id;
               req_in       = req_req_size;
               node_in      = '0;
               size_in      = SW'(TOTAL_BYTES);
               base_in      = '0;
               need_in      = SW'(1);
               res_ok_in    = 1'b0;
               res_start_in = '0;
               res_end_in   = '0;
               res_bytes_in = '0;
               res_owner_in = '0;
               if (req_cmd == CMD_ALLOC) begin
                  state_in = ST_NEED;
               end else if (req_cmd inside {CMD_BIND, CMD_FREE}) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // round the request up, one doubling a cycle
         ST_NEED: begin
            if ((need_ff < SW'(req_ff) || need_ff < SW'(MIN_BLOCK))
                && need_ff <= SW'(TOTAL_BYTES)) begin
               need_in = need_ff << 1;
            end else if (need_ff > SW'(TOTAL_BYTES)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_READ;
            end
         end

         ST_READ: begin
            state_in = ST_EVAL;
         end

         // look at the node read last cycle
         ST_EVAL: begin
            state_in = ST_NEXT;
            if (cmd_ff == CMD_ALLOC) begin
               if (size_ff < need_ff) begin
                  state_in = ST_NEXT;
               end else if (mem_rd_data.status == NS_FREE) begin
                  mem_wr_en = 1'b1;
                  if (size_ff == need_ff) begin
                     mem_wr_data  = '{status: NS_ALLOC, proc: PROC_NONE,
                                      owner: owner_ff, bytes: req_ff};
                     res_ok_in    = 1'b1;
                     res_start_in = ADDR_W'(base_ff);
                     res_end_in   = ADDR_W'(base_ff + need_ff - SW'(1));
                     res_bytes_in = req_ff;
                     res_owner_in = owner_ff;
                     state_in     = ST_DONE;
                  end else begin
                     mem_wr_data.status = NS_SPLIT;
                     state_in           = ST_SPLIT_L;
                  end
               end else if (mem_rd_data.status == NS_SPLIT && size_ff > need_ff) begin
                  node_in  = left_node;
                  size_in  = size_ff >> 1;
                  state_in = ST_READ;
               end
            end else begin
               if (mem_rd_data.status == NS_ALLOC && key_hit) begin
                  mem_wr_en    = 1'b1;
                  res_ok_in    = 1'b1;
                  res_start_in = ADDR_W'(base_ff);
                  res_end_in   = ADDR_W'(base_ff + size_ff - SW'(1));
                  if (cmd_ff == CMD_BIND) begin
                     mem_wr_data      = mem_rd_data;
                     mem_wr_data.proc = NPROC_W'(proc_ff);
                     state_in         = ST_DONE;
                  end else begin
                     mem_wr_data.status = NS_FREE;
                     res_bytes_in       = mem_rd_data.bytes;
                     res_owner_in       = mem_rd_data.owner;
                     state_in           = ST_MRG_READ;
                  end
               end else if (mem_rd_data.status == NS_SPLIT) begin
                  node_in  = left_node;
                  size_in  = size_ff >> 1;
                  state_in = ST_READ;
               end
            end
         end

         // split writes both children free, then descend left
         ST_SPLIT_L: begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = left_node;
            mem_wr_data.status = NS_FREE;
            state_in           = ST_SPLIT_R;
         end

         ST_SPLIT_R: begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = right_node;
            mem_wr_data.status = NS_FREE;
            node_in            = left_node;
            size_in            = size_ff >> 1;
            state_in           = ST_READ;
         end

         // preorder successor: climb out of right children
         ST_NEXT: begin
            if (node_ff == '0) begin
               state_in = ST_DONE;
            end else if (node_ff[0]) begin
               node_in  = node_ff + NW'(1);
               base_in  = base_ff + size_ff;
               state_in = ST_READ;
            end else begin
               node_in = parent_node;
               base_in = base_ff - size_ff;
               size_in = size_ff << 1;
            end
         end

         // merge free buddies upward
         ST_MRG_READ: begin
            mem_rd_addr = buddy_node;
            if (node_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MRG_EVAL;
            end
         end

         ST_MRG_EVAL: begin
            if (mem_rd_data.status == NS_FREE) begin
               mem_wr_en = 1'b1;
               state_in  = ST_MRG_BUD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_MRG_BUD: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = buddy_node;
            state_in    = ST_MRG_PAR;
         end

         ST_MRG_PAR: begin
            mem_wr_en          = 1'b1;
            mem_wr_addr        = parent_node;
            mem_wr_data.status = NS_FREE;
            node_in            = parent_node;
            state_in           = ST_MRG_READ;
         end

         // hand the result to the output register
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_start_in = res_start_ff;
               rsp_end_in   = res_end_ff;
               rsp_bytes_in = res_bytes_ff;
               rsp_owner_in = res_owner_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_start_addr  = rsp_start_ff;
   assign rsp_end_addr    = rsp_end_ff;
   assign rsp_used_bytes  = rsp_bytes_ff;
   assign rsp_block_owner = rsp_owner_ff;

endmodule

// ===== rtl/buddy_memory_allocator_unit.sv =====
// buddy allocator: node tree held in one node memory with registered read
// walk: allocate rounds the request up, then reads nodes, splits and takes preorder steps;
// bind and free skip rounding; free then merges free buddies level by level; the result
// register loads in ST_DONE when the output register is empty or not stalled
// one command at a time
// reset: clearing pass over all 2 * TOTAL_BYTES / MIN_BLOCK - 1 nodes, req_stall high until done
module buddy_memory_allocator_unit
   import bma_pkg::*;
#(
   parameter int TOTAL_BYTES = DEF_TOTAL_BYTES,
   parameter int MIN_BLOCK   = DEF_MIN_BLOCK
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [OWNER_W-1:0] req_owner_id,
   input  logic [PROC_W-1:0]  req_proc_id,
   input  logic [SIZE_W-1:0]  req_req_size,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [ADDR_W-1:0]  rsp_start_addr,
   output logic [ADDR_W-1:0]  rsp_end_addr,
   output logic [SIZE_W-1:0]  rsp_used_bytes,
   output logic [OWNER_W-1:0] rsp_block_owner
);

   localparam int NODE_COUNT = 2 * (TOTAL_BYTES / MIN_BLOCK) - 1;
   localparam int NW         = $clog2(NODE_COUNT);

   logic          mem_wr_en;
   logic [NW-1:0] mem_wr_addr;
   node_type      mem_wr_data;
   logic [NW-1:0] mem_rd_addr;
   node_type      mem_rd_data;

   // walk sequencer
   bma_ctrl #(
      .TOTAL_BYTES(TOTAL_BYTES),
      .MIN_BLOCK  (MIN_BLOCK)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_owner_id   (req_owner_id),
      .req_proc_id    (req_proc_id),
      .req_req_size   (req_req_size),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_start_addr (rsp_start_addr),
      .rsp_end_addr   (rsp_end_addr),
      .rsp_used_bytes (rsp_used_bytes),
      .rsp_block_owner(rsp_block_owner),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // node memory: status, process id, owner and bytes per tree node
   bma_ram #(
      .WIDTH(NODE_W),
      .DEPTH(NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

endmodule

// ===== rtl/bma_checker.sv =====
`include "buddy_memory_allocator_unit_macros.svh"

module bma_checker
   import bma_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_ok,
   input logic [ADDR_W-1:0]  rsp_start_addr,
   input logic [ADDR_W-1:0]  rsp_end_addr,
   input logic [SIZE_W-1:0]  rsp_used_bytes,
   input logic [OWNER_W-1:0] rsp_block_owner
);

   // a failed command shows all fields zero
   `BMA_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_ok, rsp_start_addr == '0 && rsp_end_addr == '0 && rsp_used_bytes == '0 && rsp_block_owner == '0, "failed result has nonzero fields")

   // one command at a time: stall right after a command transfer
   `BMA_ASSERT_NEXT(a_one_cmd, req_valid && !req_stall, req_stall, "command taken while busy")

   // reset starts the clearing pass with nothing to deliver
   `BMA_ASSERT_RESET(a_reset_clear, reset, req_stall && !rsp_valid, "not stalled after reset")

   // a waiting result stays offered
   `BMA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

endmodule

bind buddy_memory_allocator_unit bma_checker u_bma_checker (.*);
